[hw/rtl/pegd_pkg.sv]
package pegd_pkg;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned HELD_W   = 2;
   localparam int unsigned NRES_W   = 3;
   localparam int unsigned MAX_RES  = 4;
   localparam int unsigned CSR_IDX_W = 1;

   // Number of escape characters that make up a complete run.
   localparam logic [HELD_W-1:0] RUN_LENGTH = 2'd3;

   // Saturation value of both millisecond counters.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Register reset values.
   localparam logic [COUNT_W-1:0] GUARD_RESET  = 16'd900;
   localparam logic [BYTE_W-1:0]  ESCAPE_RESET = 8'h2B;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_GUARD_TIME  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_CHAR = 1'b1;

   // Input command codes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_BYTE = 1'b1;

   // Detector state carried from one transaction to the next.
   typedef struct packed {
      logic [COUNT_W-1:0] silence_ms;
      logic [COUNT_W-1:0] armed_ms;
      logic               armed;
      logic [HELD_W-1:0]  held_count;
   } state_type;

   // Configuration register values.
   typedef struct packed {
      logic [COUNT_W-1:0] guard_time_ms;
      logic [BYTE_W-1:0]  escape_char;
   } cfg_type;

   typedef logic [BYTE_W-1:0] byte_type;

   // Results caused by one input transaction, first result in slot zero.
   typedef struct packed {
      byte_type [MAX_RES-1:0] bytes;
      logic                   escape;
      logic [NRES_W-1:0]      count;
   } bundle_type;

endpackage

[hw/rtl/plus_escape_guard_detector.sv]
// The first result of a transaction is offered in the cycle after it is accepted.
// Throughput: one input transaction per cycle while each causes at most one result and the
// output is not stalled; a transaction with several results (up to four) holds the result register until all have left.
// The result register drains one result per cycle while rsp_tready is high; it is the only queue in the block.
// Reset (synchronous, active high) clears counters, run state and pending results,
// and loads guard time 900 ms and escape character '+'.
module plus_escape_guard_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] host_byte
   input  logic                            req_tuser,  // [0] command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [7:0] out_byte
   output logic                            rsp_tuser,  // [0] escape_seen
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pegd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                     csr_data
);

   pegd_pkg::cfg_type    cfg_ff, cfg_in;
   pegd_pkg::state_type  state_ff, state_in;
   pegd_pkg::bundle_type bundle;
   pegd_pkg::byte_type [pegd_pkg::MAX_RES-1:0] bytes_ff, bytes_in;
   logic                          esc_ff, esc_in;
   logic [pegd_pkg::NRES_W-1:0]   cnt_ff, cnt_in;
   logic                          req_fire;
   logic                          rsp_fire;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pegd_pkg::REG_GUARD_TIME:  cfg_in.guard_time_ms = csr_data;
            pegd_pkg::REG_ESCAPE_CHAR: cfg_in.escape_char   = csr_data[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // Per-transaction detector logic.
   pegd_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .command   (req_tuser),
      .host_byte (req_tdata),
      .state_nxt (state_in),
      .bundle    (bundle)
   );

   // Accept while the result register is empty or its last result leaves now.
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == '0) || ((cnt_ff == pegd_pkg::NRES_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Result register: loads a new bundle or shifts out one result per output handshake.
   always_comb begin
      bytes_in = bytes_ff;
      esc_in   = esc_ff;
      cnt_in   = cnt_ff;
      if (rsp_fire) begin
         for (int j = 0; j < pegd_pkg::MAX_RES - 1; j++) begin
            bytes_in[j] = bytes_ff[j+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
      if (req_fire && (bundle.count != '0)) begin
         bytes_in = bundle.bytes;
         esc_in   = bundle.escape;
         cnt_in   = bundle.count;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tuser  = esc_ff;
   assign rsp_tlast  = (cnt_ff == pegd_pkg::NRES_W'(1));

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.guard_time_ms <= pegd_pkg::GUARD_RESET;
         cfg_ff.escape_char   <= pegd_pkg::ESCAPE_RESET;
         state_ff             <= '0;
         cnt_ff               <= '0;
         esc_ff               <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
         cnt_ff <= cnt_in;
         esc_ff <= esc_in;
      end
   end

   // Result bytes need no reset.
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule

[hw/rtl/pegd_step.sv]
module pegd_step (
   input  pegd_pkg::state_type        state_cur,
   input  pegd_pkg::cfg_type          cfg,
   input  logic                       command,
   input  logic [pegd_pkg::BYTE_W-1:0] host_byte,
   output pegd_pkg::state_type        state_nxt,
   output pegd_pkg::bundle_type       bundle
);

   logic [pegd_pkg::COUNT_W-1:0] silence_inc;
   logic [pegd_pkg::COUNT_W-1:0] armed_inc;
   logic                         tick_done;
   logic                         byte_done;
   logic                         timed_out;
   logic                         armed_left;
   logic                         is_escape;
   logic                         arm_new;
   logic                         hold_more;
   logic                         pass_byte;
   logic [pegd_pkg::HELD_W-1:0]  release_cnt;

   // Saturating millisecond counters.
   assign silence_inc = (state_cur.silence_ms == pegd_pkg::COUNT_MAX) ?
                        state_cur.silence_ms : state_cur.silence_ms + 1'b1;
   assign armed_inc   = (state_cur.armed_ms == pegd_pkg::COUNT_MAX) ?
                        state_cur.armed_ms : state_cur.armed_ms + 1'b1;

   // A full run is complete once the guard time has passed after arming.
   assign tick_done = state_cur.armed && (state_cur.held_count == pegd_pkg::RUN_LENGTH) &&
                      (armed_inc >= cfg.guard_time_ms);
   assign byte_done = state_cur.armed && (state_cur.held_count == pegd_pkg::RUN_LENGTH) &&
                      (state_cur.armed_ms >= cfg.guard_time_ms);

   // A short run whose guard time ran out is released ahead of the byte.
   assign timed_out = state_cur.armed && (state_cur.held_count != '0) &&
                      (state_cur.held_count < pegd_pkg::RUN_LENGTH) &&
                      (state_cur.armed_ms >= cfg.guard_time_ms);
   assign armed_left = state_cur.armed && !timed_out;
   assign is_escape  = (host_byte == cfg.escape_char);
   assign arm_new    = !armed_left && is_escape &&
                       (state_cur.silence_ms >= cfg.guard_time_ms);
   assign hold_more  = !arm_new && armed_left && is_escape &&
                       (state_cur.held_count < pegd_pkg::RUN_LENGTH);
   assign pass_byte  = !arm_new && !hold_more;

   always_comb begin
      if (timed_out || (pass_byte && armed_left)) begin
         release_cnt = state_cur.held_count;
      end else begin
         release_cnt = '0;
      end
   end

   // Next state and the results of this transaction.
   always_comb begin
      state_nxt = state_cur;
      bundle.escape = 1'b0;
      bundle.count  = '0;
      for (int j = 0; j < pegd_pkg::MAX_RES; j++) begin
         bundle.bytes[j] = (j < int'(release_cnt)) ? cfg.escape_char : host_byte;
      end
      if (command == pegd_pkg::CMD_TICK) begin
         state_nxt.silence_ms = silence_inc;
         state_nxt.armed_ms   = armed_inc;
         if (tick_done) begin
            state_nxt.armed      = 1'b0;
            state_nxt.held_count = '0;
            bundle.escape        = 1'b1;
            bundle.bytes[0]      = '0;
            bundle.count         = pegd_pkg::NRES_W'(1);
         end
      end else if (byte_done) begin
         state_nxt.armed      = 1'b0;
         state_nxt.held_count = '0;
         state_nxt.silence_ms = '0;
         bundle.escape        = 1'b1;
         bundle.bytes[0]      = '0;
         bundle.count         = pegd_pkg::NRES_W'(1);
      end else begin
         state_nxt.silence_ms = '0;
         if (arm_new) begin
            state_nxt.armed      = 1'b1;
            state_nxt.armed_ms   = '0;
            state_nxt.held_count = pegd_pkg::HELD_W'(1);
            bundle.count         = pegd_pkg::NRES_W'(release_cnt);
         end else if (hold_more) begin
            state_nxt.held_count = state_cur.held_count + 1'b1;
         end else begin
            state_nxt.armed      = 1'b0;
            state_nxt.held_count = '0;
            bundle.count         = pegd_pkg::NRES_W'(release_cnt) + 1'b1;
         end
      end
   end

endmodule

[hw/rtl/pegd_checker.sv]
module pegd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // An escape result carries a zero byte and is the only result of its transaction.
   a_escape_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == 8'd0) && rsp_tlast)
      else $error("malformed escape result");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Input is only refused while results are waiting.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input refused with no pending result");

endmodule

bind plus_escape_guard_detector pegd_checker u_pegd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
